/* src/fpps_pkg.sv */
package fpps_pkg;

    typedef enum logic [1:0] {
        PH_MAIN = 2'd0,
        PH_GAP  = 2'd1,
        PH_AUX  = 2'd2,
        PH_OFF  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        REG_OFF  = 2'd0,
        REG_MAIN = 2'd1,
        REG_GAP  = 2'd2,
        REG_AUX  = 2'd3
    } t_reg_idx;

    localparam int unsigned CFG_W = 16;

    localparam logic [15:0] RST_OFF_TICKS  = 16'd200;
    localparam logic [7:0]  RST_MAIN_TICKS = 8'd50;
    localparam logic [7:0]  RST_GAP_TICKS  = 8'd20;
    localparam logic [7:0]  RST_AUX_TICKS  = 8'd12;

    typedef struct packed {
        logic             we;
        t_reg_idx         idx;
        logic [CFG_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic   main_pulse;
        logic   aux_pulse;
        t_phase phase;
    } t_result;

endpackage

/* src/fpps_core.sv */
module fpps_core
    import fpps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_cfg_wr i_cfg,
    output t_result o_result
);

    logic [15:0] r_off_lim;
    logic [7:0]  r_main_lim;
    logic [7:0]  r_gap_lim;
    logic [7:0]  r_aux_lim;

    t_phase      r_phase,      n_phase;
    logic [8:0]  r_main_count, n_main_count;
    logic [8:0]  r_gap_count,  n_gap_count;
    logic [8:0]  r_aux_count,  n_aux_count;
    logic [16:0] r_off_count,  n_off_count;
    logic        r_main_level, n_main_level;
    logic        r_aux_level,  n_aux_level;

    logic        advance;
    logic [8:0]  main_inc;
    logic [8:0]  gap_inc;
    logic [8:0]  aux_inc;
    logic [16:0] off_inc;

    assign main_inc = r_main_count + 9'd1;
    assign gap_inc  = r_gap_count + 9'd1;
    assign aux_inc  = r_aux_count + 9'd1;
    assign off_inc  = r_off_count + 17'd1;

    // next state: advance the counter of the current phase, end the phase past its limit
    always_comb begin
        n_phase      = r_phase;
        n_main_count = r_main_count;
        n_gap_count  = r_gap_count;
        n_aux_count  = r_aux_count;
        n_off_count  = r_off_count;
        advance      = 1'b0;
        if (i_step) begin
            case (r_phase)
                PH_MAIN: begin
                    if (main_inc > {1'b0, r_main_lim}) begin
                        n_main_count = '0;
                        n_phase      = PH_GAP;
                        advance      = 1'b1;
                    end else begin
                        n_main_count = main_inc;
                    end
                end
                PH_GAP: begin
                    if (gap_inc > {1'b0, r_gap_lim}) begin
                        n_gap_count = '0;
                        n_phase     = PH_AUX;
                        advance     = 1'b1;
                    end else begin
                        n_gap_count = gap_inc;
                    end
                end
                PH_AUX: begin
                    if (aux_inc > {1'b0, r_aux_lim}) begin
                        n_aux_count = '0;
                        n_phase     = PH_OFF;
                        advance     = 1'b1;
                    end else begin
                        n_aux_count = aux_inc;
                    end
                end
                default: begin
                    if (off_inc > {1'b0, r_off_lim}) begin
                        n_off_count = '0;
                        n_phase     = PH_MAIN;
                        advance     = 1'b1;
                    end else begin
                        n_off_count = off_inc;
                    end
                end
            endcase
        end
        // a duration write drops that phase's count
        if (i_cfg.we) begin
            case (i_cfg.idx)
                REG_OFF:  n_off_count  = '0;
                REG_MAIN: n_main_count = '0;
                REG_GAP:  n_gap_count  = '0;
                REG_AUX:  n_aux_count  = '0;
                default:  ;
            endcase
        end
    end

    // output levels change only on a phase change
    always_comb begin
        n_main_level = r_main_level;
        n_aux_level  = r_aux_level;
        if (advance) begin
            n_main_level = (n_phase == PH_MAIN);
            n_aux_level  = (n_phase == PH_AUX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_lim    <= RST_OFF_TICKS;
            r_main_lim   <= RST_MAIN_TICKS;
            r_gap_lim    <= RST_GAP_TICKS;
            r_aux_lim    <= RST_AUX_TICKS;
            r_phase      <= PH_OFF;
            r_main_count <= '0;
            r_gap_count  <= '0;
            r_aux_count  <= '0;
            r_off_count  <= '0;
            r_main_level <= 1'b0;
            r_aux_level  <= 1'b0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    REG_OFF:  r_off_lim  <= i_cfg.data;
                    REG_MAIN: r_main_lim <= i_cfg.data[7:0];
                    REG_GAP:  r_gap_lim  <= i_cfg.data[7:0];
                    REG_AUX:  r_aux_lim  <= i_cfg.data[7:0];
                    default:  ;
                endcase
            end
            r_phase      <= n_phase;
            r_main_count <= n_main_count;
            r_gap_count  <= n_gap_count;
            r_aux_count  <= n_aux_count;
            r_off_count  <= n_off_count;
            r_main_level <= n_main_level;
            r_aux_level  <= n_aux_level;
        end
    end

    assign o_result.main_pulse = n_main_level;
    assign o_result.aux_pulse  = n_aux_level;
    assign o_result.phase      = n_phase;

    a_main_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_main_level |-> (r_phase == PH_MAIN))
        else $error("main pulse high outside main phase");

    a_aux_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_aux_level |-> (r_phase == PH_AUX))
        else $error("aux pulse high outside aux phase");

    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase))
        else $error("phase moved without a tick");

    a_main_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg.we && i_cfg.idx == REG_MAIN) |=> (r_main_count == 9'd0))
        else $error("main count not cleared by register write");

endmodule

/* src/four_phase_pulse_sequencer.sv */
// Each result is registered in the result register, or the skid register on a stall.
// Throughput: one word per cycle while o_stall is low; the update is one increment and
// compare. A two-entry output stage (result register plus skid register) keeps input
// flowing while one result waits; o_stall rises only when both entries are full.
// Reset (i_rst_n low at a clock edge): off phase, all counters zero, both pulses low,
// durations 200/50/20/12 for off/main/gap/aux, output stage empty.
module four_phase_pulse_sequencer
    import fpps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_tick,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_main_pulse,
    output logic             o_aux_pulse,
    output logic [1:0]       o_phase,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_cfg_wr cfg;
    t_result result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;
    logic    in_acc;
    logic    out_free;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = t_reg_idx'(i_cfg_index);
    assign cfg.data = i_cfg_data;

    assign o_stall  = r_skid_valid;
    assign in_acc   = i_valid && !r_skid_valid;
    assign out_free = !r_out_valid || !i_stall;

    fpps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (in_acc && i_tick),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            // refill from the skid word first, else from the new word
            r_out_valid  <= r_skid_valid || in_acc;
            r_skid_valid <= 1'b0;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (in_acc) begin
                r_out <= result;
            end
        end else if (in_acc) begin
            r_skid <= result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_main_pulse = r_out.main_pulse;
    assign o_aux_pulse  = r_out.aux_pulse;
    assign o_phase      = r_out.phase;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with output register empty");

    a_stalled_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result word lost");

    a_empty_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_out_valid) |=> (r_out_valid && !r_skid_valid))
        else $error("word into empty stage not placed in output register");

endmodule

/* sim/tb.sv */
module tb;
    import fpps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_WORDS = 150;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             i_tick = 1'b0;
    logic             i_stall = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_index = REG_OFF;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             o_stall;
    logic             o_valid;
    logic             o_main_pulse;
    logic             o_aux_pulse;
    logic [1:0]       o_phase;

    four_phase_pulse_sequencer i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_tick       (i_tick),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_main_pulse (o_main_pulse),
        .o_aux_pulse  (o_aux_pulse),
        .o_phase      (o_phase),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // sequencer state as the testbench sees it
    t_phase      sq_phase;
    logic [8:0]  sq_main_cnt;
    logic [8:0]  sq_gap_cnt;
    logic [8:0]  sq_aux_cnt;
    logic [16:0] sq_off_cnt;
    logic        sq_main_lvl;
    logic        sq_aux_lvl;
    logic [15:0] lim_off;
    logic [7:0]  lim_main;
    logic [7:0]  lim_gap;
    logic [7:0]  lim_aux;

    t_result pulse_expect_q[$];
    int      err_count = 0;
    int      burst_left = 0;
    int      hold_len = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void reset_sequencer();
        sq_phase    = PH_OFF;
        sq_main_cnt = '0;
        sq_gap_cnt  = '0;
        sq_aux_cnt  = '0;
        sq_off_cnt  = '0;
        sq_main_lvl = 1'b0;
        sq_aux_lvl  = 1'b0;
        lim_off     = RST_OFF_TICKS;
        lim_main    = RST_MAIN_TICKS;
        lim_gap     = RST_GAP_TICKS;
        lim_aux     = RST_AUX_TICKS;
    endfunction

    function automatic t_result step_sequencer(input logic tick);
        t_result r;
        if (tick) begin
            case (sq_phase)
                PH_MAIN: begin
                    sq_main_cnt = sq_main_cnt + 9'd1;
                    if (sq_main_cnt > {1'b0, lim_main}) begin
                        sq_main_cnt = '0;
                        sq_phase    = PH_GAP;
                        sq_main_lvl = 1'b0;
                        sq_aux_lvl  = 1'b0;
                    end
                end
                PH_GAP: begin
                    sq_gap_cnt = sq_gap_cnt + 9'd1;
                    if (sq_gap_cnt > {1'b0, lim_gap}) begin
                        sq_gap_cnt  = '0;
                        sq_phase    = PH_AUX;
                        sq_main_lvl = 1'b0;
                        sq_aux_lvl  = 1'b1;
                    end
                end
                PH_AUX: begin
                    sq_aux_cnt = sq_aux_cnt + 9'd1;
                    if (sq_aux_cnt > {1'b0, lim_aux}) begin
                        sq_aux_cnt  = '0;
                        sq_phase    = PH_OFF;
                        sq_main_lvl = 1'b0;
                        sq_aux_lvl  = 1'b0;
                    end
                end
                default: begin
                    sq_off_cnt = sq_off_cnt + 17'd1;
                    if (sq_off_cnt > {1'b0, lim_off}) begin
                        sq_off_cnt  = '0;
                        sq_phase    = PH_MAIN;
                        sq_main_lvl = 1'b1;
                        sq_aux_lvl  = 1'b0;
                    end
                end
            endcase
        end
        r.main_pulse = sq_main_lvl;
        r.aux_pulse  = sq_aux_lvl;
        r.phase      = sq_phase;
        return r;
    endfunction

    // Send one tick word; the sender runs in bursts with random gaps between them.
    task automatic send_tick(input logic t);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
        end
        i_valid <= 1'b1;
        i_tick  <= t;
        burst_left--;
        do @(posedge i_clk); while (o_stall);
        pulse_expect_q.push_back(step_sequencer(t));
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
        i_tick  <= $urandom_range(0, 1);
    endtask

    // Drop valid, let every expected word arrive, then settle past the output stage.
    task automatic wait_drained();
        hold_input();
        while (pulse_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            REG_OFF: begin
                lim_off    = val;
                sq_off_cnt = '0;
            end
            REG_MAIN: begin
                lim_main    = val[7:0];
                sq_main_cnt = '0;
            end
            REG_GAP: begin
                lim_gap    = val[7:0];
                sq_gap_cnt = '0;
            end
            default: begin
                lim_aux    = val[7:0];
                sq_aux_cnt = '0;
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Upper byte of the 8-bit durations is random and must be dropped by the block.
    task automatic set_durations(input logic [15:0] off_t, input logic [7:0] main_t,
                                 input logic [7:0] gap_t, input logic [7:0] aux_t);
        write_reg(REG_OFF, off_t);
        write_reg(REG_MAIN, {8'($urandom), main_t});
        write_reg(REG_GAP, {8'($urandom), gap_t});
        write_reg(REG_AUX, {8'($urandom), aux_t});
    endtask

    function automatic logic [15:0] pick_duration(input t_reg_idx idx);
        int r;
        r = $urandom_range(0, 19);
        if (idx == REG_OFF) begin
            return (r < 15) ? 16'($urandom_range(0, 15)) : 16'($urandom_range(0, 300));
        end
        return {8'($urandom), (r < 15) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255))};
    endfunction

    task automatic test_idle_ticks();
        repeat (3) send_tick(1'b0);
        repeat (2) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // Every tick ends a phase when all durations are zero.
    task automatic test_zero_durations();
        wait_drained();
        set_durations(16'd0, 8'd0, 8'd0, 8'd0);
        repeat (10) send_tick(1'b1);
        send_tick(1'b0);
    endtask

    // Rewrite durations mid-phase, lower than the count already reached.
    task automatic test_rewrite_mid_phase();
        wait_drained();
        set_durations(16'd9, 8'd9, 8'd9, 8'd9);
        repeat (5) send_tick(1'b1);
        wait_drained();
        set_durations(16'd2, 8'd2, 8'd2, 8'd2);
        repeat (6) send_tick(1'b1);
    endtask

    task automatic test_receiver_hold();
        wait_drained();
        set_durations(16'd3, 8'd1, 8'd2, 8'd1);
        hold_len = 300;
        repeat (60) send_tick($urandom_range(0, 7) != 0);
    endtask

    task automatic test_random_run();
        int sent;
        int seg_len;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            wait_drained();
            if ($urandom_range(0, 2) != 0) write_reg(REG_OFF, pick_duration(REG_OFF));
            if ($urandom_range(0, 2) != 0) write_reg(REG_MAIN, pick_duration(REG_MAIN));
            if ($urandom_range(0, 2) != 0) write_reg(REG_GAP, pick_duration(REG_GAP));
            if ($urandom_range(0, 2) != 0) write_reg(REG_AUX, pick_duration(REG_AUX));
            seg_len = $urandom_range(20, 80);
            repeat (seg_len) send_tick($urandom_range(0, 7) != 0);
            sent += seg_len;
        end
    endtask

    // Full round with the 8-bit limits at their top; counters must not wrap.
    // Then put the off limit at its top and make sure the off phase does not end early.
    task automatic test_largest_limits();
        int ones;
        logic t;
        wait_drained();
        set_durations(16'd2, 8'hFF, 8'hFF, 8'hFF);
        ones = 0;
        while (ones < 3 * 256 + 3 + 8) begin
            t = ($urandom_range(0, 15) != 0);
            send_tick(t);
            if (t) ones++;
        end
        wait_drained();
        write_reg(REG_OFF, 16'hFFFF);
        repeat (16) send_tick(1'b1);
    endtask

    // Receiver: stall pattern that changes mode now and then, plus requested long holds.
    initial begin
        int pct;
        int mode_left;
        pct = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_len > 0) begin
                i_stall <= 1'b1;
                hold_len--;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(32, 256);
                    case ($urandom_range(0, 3))
                        0: pct = 0;
                        1: pct = 15;
                        2: pct = 50;
                        default: pct = 85;
                    endcase
                end
                mode_left--;
                i_stall <= ($urandom_range(0, 99) < pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pulse_expect_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected pulse word: main=%0b aux=%0b phase=%0d",
                             o_main_pulse, o_aux_pulse, o_phase);
            end else begin
                want = pulse_expect_q.pop_front();
                if (o_main_pulse !== want.main_pulse || o_aux_pulse !== want.aux_pulse ||
                    o_phase !== want.phase) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("pulse word error: expected main=%0b aux=%0b phase=%0d,",
                                 want.main_pulse, want.aux_pulse, want.phase,
                                 " got main=%0b aux=%0b phase=%0d",
                                 o_main_pulse, o_aux_pulse, o_phase);
                end
            end
        end
    end

    // Watchdog: end the run after too many cycles without a handshake on either side.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("four_phase_pulse_sequencer: mismatch");
        $finish;
    end

    initial begin
        reset_sequencer();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_ticks();
        test_zero_durations();
        test_rewrite_mid_phase();
        test_receiver_hold();
        test_random_run();
        test_largest_limits();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (err_count == 0 && pulse_expect_q.size() == 0)
            $display("four_phase_pulse_sequencer: match");
        else
            $display("four_phase_pulse_sequencer: mismatch");
        $finish;
    end

endmodule

/* files.f */
src/fpps_pkg.sv
src/fpps_core.sv
src/four_phase_pulse_sequencer.sv
sim/tb.sv
